/* rtl/core/brc_pkg.sv */
// ----------------------------------------------------------------------------
// BCD real-time clock package
// Access codes, calendar limits and the BCD conversion helpers shared by the
// real-time clock and calendar block.
// ----------------------------------------------------------------------------
package brc_pkg;

   // Access codes carried with each request.
   typedef enum logic [2:0] {
      FUNC_TICK       = 3'd0,
      FUNC_READ_DATE  = 3'd1,
      FUNC_WRITE_DATE = 3'd2,
      FUNC_READ_TIME  = 3'd3,
      FUNC_WRITE_TIME = 3'd4
   } func_type;

   // Field widths.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned NIB_W   = 4;
   localparam int unsigned YEAR_W  = 16;
   localparam int unsigned YMOD_W  = 7;

   // Rollover limits and reset values.
   localparam logic [BYTE_W-1:0]  SECOND_LIMIT   = 8'd60;
   localparam logic [BYTE_W-1:0]  MINUTE_LIMIT   = 8'd60;
   localparam logic [BYTE_W-1:0]  HOUR_LIMIT     = 8'd24;
   localparam logic [NIB_W-1:0]   MONTH_LIMIT    = 4'd12;
   localparam logic [BYTE_W-1:0]  DIVIDE_RESET   = 8'd5;
   localparam logic [YEAR_W-1:0]  YEAR_RESET     = 16'd2000;
   localparam logic [YMOD_W-1:0]  YEAR_MOD_RESET = 7'd0;
   localparam logic [YMOD_W-1:0]  YEAR_MOD_LAST  = 7'd99;
   localparam logic [YEAR_W-1:0]  YEAR_LAST      = 16'hFFFF;
   localparam logic [YEAR_W-1:0]  CENTURY_BASE   = 16'd1900;
   localparam logic [8:0]         YEAR_PIVOT     = 9'd80;
   localparam logic [8:0]         CENTURY        = 9'd100;

   // BCD to binary: high nibble times ten plus low nibble, non-decimal
   // digits included.
   function automatic logic [BYTE_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] hi_x10;
      hi_x10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
      return hi_x10 + {4'b0000, b[3:0]};
   endfunction

   // Binary to BCD for a value up to 99. The quotient by ten comes from a
   // reciprocal multiply, exact for every 8-bit input.
   function automatic logic [BYTE_W-1:0] bin_to_bcd(input logic [BYTE_W-1:0] v);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [7:0]  rem;
      prod = {8'd0, v} * 16'd205;
      quot = prod[15:11];
      rem  = v - ({3'b000, quot} * 8'd10);
      return {quot[3:0], 4'b0000} + rem;
   endfunction

   // Number of days in a month; February gains a day in leap years and
   // months outside one to twelve get thirty days.
   function automatic logic [4:0] month_days(input logic [NIB_W-1:0] month,
                                             input logic leap);
      logic [4:0] days;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
         4'd2:                                       days = leap ? 5'd29 : 5'd28;
         default:                                    days = 5'd30;
      endcase
      return days;
   endfunction

   // Next weekday, modulo seven, for any 4-bit starting value.
   function automatic logic [NIB_W-1:0] weekday_next(input logic [NIB_W-1:0] w);
      logic [4:0] n;
      n = {1'b0, w} + 5'd1;
      if (n >= 5'd14) begin
         n = n - 5'd14;
      end else if (n >= 5'd7) begin
         n = n - 5'd7;
      end
      return n[3:0];
   endfunction

endpackage

/* rtl/core/bcd_rtc_calendar.sv */
// ----------------------------------------------------------------------------
// BCD real-time clock and calendar
// Tick prescaler, time of day and calendar counters with a BCD register
// interface for date and time reads and writes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transfer unit
//   req_*     in         one access: func in tuser, three BCD bytes in tdata
//   rsp_*     out        one result per access: three BCD bytes in tdata
//   csr_*     in         one write of the tick divide register
//
// Every access passes from transfer in through the request register, then
// one pass of the counter logic into the result register, to result out.
// A new access is taken every cycle while results are drained.
// The request and result registers form a two-entry pipeline, so a stalled
// result still leaves room for one more request.
// Reset is synchronous and active high; it clears the pipeline, holds both
// ready outputs low and loads the clock with 00:00:00, day 1, month 1,
// weekday 0, year 2000, divide 5.
//
module bcd_rtc_calendar (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // in_low_byte, in_mid_byte, in_high_byte
   input  logic [2:0]  req_tuser,  // func
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_low_byte, out_mid_byte, out_high_byte
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data    // tick_divide
);

   // Request register.
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_func_ff;
   logic [7:0]  s1_low_ff, s1_mid_ff, s1_high_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_low_ff, rsp_low_in;
   logic [7:0]  rsp_mid_ff, rsp_mid_in;
   logic [7:0]  rsp_high_ff, rsp_high_in;
   logic        rsp_read_ff, rsp_read_in;

   // Clock and calendar state.
   logic [7:0]  divide_ff;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  minute_ff, minute_in;
   logic [7:0]  hour_ff, hour_in;
   logic [7:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [3:0]  weekday_ff, weekday_in;
   logic [15:0] year_ff, year_in;
   logic [6:0]  year_mod_ff, year_mod_in;

   // Handshake and pipeline control.
   logic        s1_advance;
   logic        req_xfer;
   logic        sec_advance;
   logic        day_roll;

   // Scratch values of the update pass.
   logic [8:0]  tick_sum;
   logic [7:0]  sec_inc, min_inc, hour_inc;
   logic [8:0]  day_inc;
   logic [4:0]  day_limit;
   logic [4:0]  month_inc;
   logic [7:0]  year_bin;
   logic [8:0]  year_shift;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!s1_valid_ff || s1_advance);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_high_ff, rsp_mid_ff, rsp_low_ff};

   // Pipeline occupancy.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Update pass: one access against the current state.
   always_comb begin
      tick_count_in = tick_count_ff;
      second_in     = second_ff;
      minute_in     = minute_ff;
      hour_in       = hour_ff;
      day_in        = day_ff;
      month_in      = month_ff;
      weekday_in    = weekday_ff;
      year_in       = year_ff;
      year_mod_in   = year_mod_ff;
      rsp_low_in    = 8'd0;
      rsp_mid_in    = 8'd0;
      rsp_high_in   = 8'd0;
      rsp_read_in   = 1'b0;
      sec_advance   = 1'b0;
      day_roll      = 1'b0;

      tick_sum   = {1'b0, tick_count_ff} + 9'd1;
      sec_inc    = second_ff + 8'd1;
      min_inc    = minute_ff + 8'd1;
      hour_inc   = hour_ff + 8'd1;
      day_inc    = {1'b0, day_ff} + 9'd1;
      day_limit  = brc_pkg::month_days(month_ff, year_ff[1:0] == 2'b00);
      month_inc  = {1'b0, month_ff} + 5'd1;
      year_bin   = brc_pkg::bcd_to_bin(s1_high_ff);
      year_shift = ({1'b0, year_bin} < brc_pkg::YEAR_PIVOT)
                   ? {1'b0, year_bin} + brc_pkg::CENTURY : {1'b0, year_bin};

      case (brc_pkg::func_type'(s1_func_ff))
         brc_pkg::FUNC_TICK: begin
            // Prescaler; a reached divide count advances one second.
            if (tick_sum >= {1'b0, divide_ff}) begin
               tick_sum    = tick_sum - {1'b0, divide_ff};
               sec_advance = 1'b1;
            end
            tick_count_in = tick_sum[7:0];
            if (sec_advance) begin
               if (sec_inc < brc_pkg::SECOND_LIMIT) begin
                  second_in = sec_inc;
               end else begin
                  second_in = 8'd0;
                  if (min_inc < brc_pkg::MINUTE_LIMIT) begin
                     minute_in = min_inc;
                  end else begin
                     minute_in = 8'd0;
                     if (hour_inc < brc_pkg::HOUR_LIMIT) begin
                        hour_in = hour_inc;
                     end else begin
                        // Midnight: weekday and day advance.
                        hour_in    = 8'd0;
                        weekday_in = brc_pkg::weekday_next(weekday_ff);
                        if (day_inc <= {4'd0, day_limit}) begin
                           day_in = day_inc[7:0];
                        end else begin
                           day_in   = 8'd1;
                           day_roll = 1'b1;
                           if (month_inc <= {1'b0, brc_pkg::MONTH_LIMIT}) begin
                              month_in = month_inc[3:0];
                           end else begin
                              month_in = 4'd1;
                              year_in  = year_ff + 16'd1;
                              if (year_ff == brc_pkg::YEAR_LAST) begin
                                 year_mod_in = 7'd0;
                              end else if (year_mod_ff == brc_pkg::YEAR_MOD_LAST) begin
                                 year_mod_in = 7'd0;
                              end else begin
                                 year_mod_in = year_mod_ff + 7'd1;
                              end
                           end
                        end
                     end
                  end
               end
            end
         end
         brc_pkg::FUNC_READ_DATE: begin
            rsp_read_in = 1'b1;
            rsp_high_in = brc_pkg::bin_to_bcd({1'b0, year_mod_ff});
            rsp_mid_in  = {month_ff, weekday_ff};
            rsp_low_in  = brc_pkg::bin_to_bcd(day_ff);
         end
         brc_pkg::FUNC_WRITE_DATE: begin
            // The two-digit year lands in 1980 through 2079.
            year_in     = brc_pkg::CENTURY_BASE + {7'd0, year_shift};
            year_mod_in = (year_shift >= brc_pkg::CENTURY)
                          ? 7'(year_shift - brc_pkg::CENTURY) : year_shift[6:0];
            weekday_in  = s1_mid_ff[3:0];
            month_in    = s1_mid_ff[7:4];
            day_in      = brc_pkg::bcd_to_bin(s1_low_ff);
         end
         brc_pkg::FUNC_READ_TIME: begin
            rsp_read_in = 1'b1;
            rsp_high_in = brc_pkg::bin_to_bcd(hour_ff);
            rsp_mid_in  = brc_pkg::bin_to_bcd(minute_ff);
            rsp_low_in  = brc_pkg::bin_to_bcd(second_ff);
         end
         brc_pkg::FUNC_WRITE_TIME: begin
            hour_in   = brc_pkg::bcd_to_bin(s1_high_ff);
            minute_in = brc_pkg::bcd_to_bin(s1_mid_ff);
            second_in = brc_pkg::bcd_to_bin(s1_low_ff);
         end
         default: begin
            // Unused codes change nothing and return zeros.
         end
      endcase
   end

   // Control registers and clock state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         divide_ff     <= brc_pkg::DIVIDE_RESET;
         tick_count_ff <= 8'd0;
         second_ff     <= 8'd0;
         minute_ff     <= 8'd0;
         hour_ff       <= 8'd0;
         day_ff        <= 8'd1;
         month_ff      <= 4'd1;
         weekday_ff    <= 4'd0;
         year_ff       <= brc_pkg::YEAR_RESET;
         year_mod_ff   <= brc_pkg::YEAR_MOD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            divide_ff <= csr_data;
         end
         if (s1_advance) begin
            tick_count_ff <= tick_count_in;
            second_ff     <= second_in;
            minute_ff     <= minute_in;
            hour_ff       <= hour_in;
            day_ff        <= day_in;
            month_ff      <= month_in;
            weekday_ff    <= weekday_in;
            year_ff       <= year_in;
            year_mod_ff   <= year_mod_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_func_ff <= req_tuser;
         s1_low_ff  <= req_tdata[7:0];
         s1_mid_ff  <= req_tdata[15:8];
         s1_high_ff <= req_tdata[23:16];
      end
      if (s1_advance) begin
         rsp_low_ff  <= rsp_low_in;
         rsp_mid_ff  <= rsp_mid_in;
         rsp_high_ff <= rsp_high_in;
         rsp_read_ff <= rsp_read_in;
      end
   end

   // Results of anything but a read are all zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_read_ff |-> rsp_tdata == 24'd0)
      else $error("non-read result carries data");

   // A second advance always leaves the seconds in range.
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && sec_advance |=> second_ff < brc_pkg::SECOND_LIMIT)
      else $error("second out of range after advance");

   // A month rollover restarts the day at one.
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && day_roll |=> day_ff == 8'd1)
      else $error("day not restarted after month rollover");

   // The request register holds while the pipeline is stalled.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_func_ff)
         && $stable(s1_low_ff) && $stable(s1_mid_ff) && $stable(s1_high_ff))
      else $error("stalled request register changed");

endmodule
